FILE: hdl/scs_pkg.sv
// Package for the sine/cosine series unit: working-format constants, the
// context carried down the term pipeline and the per-order divisor table.
// No dependencies.
package scs_pkg;

  // working format: unsigned magnitudes with 30 fraction bits
  localparam int unsigned FracBits  = 30;
  localparam int unsigned TermW     = 36;  // series term magnitude
  localparam int unsigned AccW      = 37;  // signed running sum
  localparam int unsigned NumW      = 38;  // rounded product plus half divisor
  localparam int unsigned RcpShift  = 37;  // reciprocal scaling 2^37
  localparam int unsigned DivW      = 11;  // (n-1)n fits 11 bits
  localparam int unsigned NumGroups = 20;  // cosine orders 2..40
  localparam int unsigned SineTerms = 19;  // sine orders 3..39

  // pi and 2*pi rounded to the working format, 1.0 in the same format
  localparam logic [35:0] PiW    = 36'd3373259426;
  localparam logic [35:0] TwoPiW = 36'd6746518852;
  localparam logic [35:0] OneW   = 36'h0_4000_0000;
  localparam logic [31:0] PiA    = 32'd3373259426;

  // lane codes
  localparam logic LaneSin = 1'b0;
  localparam logic LaneCos = 1'b1;

  // state of one item as it moves from group to group
  typedef struct packed {
    logic                  neg;   // reduced angle was negative
    logic [35:0]           a2;    // x^2 in working format
    logic [1:0][TermW-1:0] term;  // latest term of each lane, not yet summed
    logic [1:0][AccW-1:0]  acc;   // running sums, two's complement
  } scs_ctx_t;

  // divisor (n-1)n for group g: cosine order 2g+2, sine order 2g+3
  function automatic logic [DivW-1:0] term_div(input int unsigned g, input logic lane);
    int unsigned n;
    n = (lane == LaneCos) ? (2 * g + 2) : (2 * g + 3);
    return DivW'((n - 1) * n);
  endfunction

endpackage

FILE: hdl/scs_in_if.sv
// Input channel of the sine/cosine series unit: valid/ready and the angle.
// No dependencies.
interface scs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

FILE: hdl/scs_out_if.sv
// Output channel of the sine/cosine series unit: valid/ready, sine and cosine.
// No dependencies.
interface scs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sine;
  logic signed [31:0] cosine;

  modport source (output valid, output sine, output cosine, input ready);
  modport sink   (input valid, input sine, input cosine, output ready);
endinterface

FILE: hdl/sine_cosine_series_unit.sv
// Sine/cosine series unit top level: range reduction, x^2 and the term pipeline.
// Depends on scs_pkg, scs_in_if and scs_out_if.

// Takes one angle (Q3.28 radians) per transfer and returns its sine and cosine
// (Q1.30, saturated to +-1.0). The unit is a fully pipelined datapath: a new
// angle can be taken every cycle unless the output stalls, and each result
// passes through 106 register stages (four for range reduction and x^2, five
// per series group over twenty groups, two for the final sum and saturation).
// When the result is not taken the whole pipeline holds; nothing is dropped.
module sine_cosine_series_unit (
  input  logic clk_i,
  input  logic rst_ni,
  scs_in_if.sink   in_i,
  scs_out_if.source out_o
);
  import scs_pkg::*;

  logic en;
  logic out_vld_q;

  // global advance: move when the output register is free or being taken
  assign en       = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // ---------------- front end ----------------
  logic               v0_q, v1_q, v2_q, v3_q;
  logic signed [31:0] ang_q;
  logic signed [36:0] xr_d, xr_q;
  logic               neg_q;
  logic [31:0]        a_q;
  logic [36:0]        a_abs;
  logic [63:0]        sq;
  logic [64:0]        sq_rnd;
  scs_ctx_t           ctx0_d, ctx0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // range reduction: one turn is enough, |angle| <= 8 < 3*pi
  always_comb begin
    logic signed [36:0] xw, pis;
    xw  = {{3{ang_q[31]}}, ang_q, 2'b00};
    pis = $signed({1'b0, PiW});
    if (xw > pis) begin
      xr_d = xw - $signed({1'b0, TwoPiW});
    end else if (xw < -pis) begin
      xr_d = xw + $signed({1'b0, TwoPiW});
    end else begin
      xr_d = xw;
    end
  end

  assign a_abs  = xr_q[36] ? 37'(-xr_q) : 37'(xr_q);
  assign sq     = 64'(a_q) * 64'(a_q);
  assign sq_rnd = 65'(sq) + 65'h2000_0000;

  always_comb begin
    ctx0_d               = '0;
    ctx0_d.neg           = neg_q;
    ctx0_d.a2            = 36'(sq_rnd[64:FracBits]);
    ctx0_d.term[LaneSin] = TermW'(a_q);
    ctx0_d.term[LaneCos] = OneW;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q  <= in_i.angle;
      xr_q   <= xr_d;
      neg_q  <= xr_q[36];
      a_q    <= a_abs[31:0];
      ctx0_q <= ctx0_d;
    end
  end

  // ---------------- term pipeline ----------------
  scs_ctx_t grp_ctx [NumGroups+1];
  logic     grp_vld [NumGroups+1];

  assign grp_ctx[0] = ctx0_q;
  assign grp_vld[0] = v3_q;

  for (genvar g = 0; g < NumGroups; g++) begin : g_grp
    localparam logic [1:0][DivW-1:0] DIV = {term_div(g, LaneCos), term_div(g, LaneSin)};
    localparam logic [1:0][36:0] RCP = {37'((64'd1 << RcpShift) / DIV[1]),
                                        37'((64'd1 << RcpShift) / DIV[0])};
    localparam logic [1:0] ACT = {1'b1, (g < SineTerms) ? 1'b1 : 1'b0};

    logic va_q, vb_q, vc_q, vd_q, ve_q;
    scs_ctx_t ca_d, ca_q, cb_q, cc_q, cd_q, ce_d, ce_q;
    logic [1:0][3:0][35:0] ppa_d, ppa_q;
    logic [1:0][NumW-1:0]  nb_d, nb_q, nc_q, nd_q;
    logic [1:0][3:0][37:0] ppc_d, ppc_q;
    logic [1:0][36:0]      q0_d, q0_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q <= 1'b0;
        vb_q <= 1'b0;
        vc_q <= 1'b0;
        vd_q <= 1'b0;
        ve_q <= 1'b0;
      end else if (en) begin
        va_q <= grp_vld[g];
        vb_q <= va_q;
        vc_q <= vb_q;
        vd_q <= vc_q;
        ve_q <= vd_q;
      end
    end

    // A: add (even group) or subtract (odd group) the pending term, partial products of term * x^2
    always_comb begin
      ca_d = grp_ctx[g];
      for (int l = 0; l < 2; l++) begin
        if (g % 2 == 0) begin
          ca_d.acc[l] = grp_ctx[g].acc[l] + {1'b0, grp_ctx[g].term[l]};
        end else begin
          ca_d.acc[l] = grp_ctx[g].acc[l] - {1'b0, grp_ctx[g].term[l]};
        end
        ppa_d[l][0] = grp_ctx[g].term[l][17:0]  * grp_ctx[g].a2[17:0];
        ppa_d[l][1] = grp_ctx[g].term[l][17:0]  * grp_ctx[g].a2[35:18];
        ppa_d[l][2] = grp_ctx[g].term[l][35:18] * grp_ctx[g].a2[17:0];
        ppa_d[l][3] = grp_ctx[g].term[l][35:18] * grp_ctx[g].a2[35:18];
      end
    end

    // B: full product, round at the working point, add half the divisor
    always_comb begin
      logic [71:0] pf;
      logic [71:0] pr;
      for (int l = 0; l < 2; l++) begin
        pf = 72'(ppa_q[l][0]) + ((72'(ppa_q[l][1]) + 72'(ppa_q[l][2])) << 18)
           + (72'(ppa_q[l][3]) << 36);
        pr = pf + 72'h2000_0000;
        nb_d[l] = NumW'(pr >> FracBits) + NumW'(DIV[l] >> 1);
      end
    end

    // C: partial products of numerator * reciprocal
    always_comb begin
      logic [37:0] rp;
      for (int l = 0; l < 2; l++) begin
        rp = {1'b0, RCP[l]};
        ppc_d[l][0] = nb_q[l][18:0]  * rp[18:0];
        ppc_d[l][1] = nb_q[l][18:0]  * rp[37:19];
        ppc_d[l][2] = nb_q[l][37:19] * rp[18:0];
        ppc_d[l][3] = nb_q[l][37:19] * rp[37:19];
      end
    end

    // D: quotient estimate, low by at most one
    always_comb begin
      logic [75:0] nr;
      for (int l = 0; l < 2; l++) begin
        nr = 76'(ppc_q[l][0]) + ((76'(ppc_q[l][1]) + 76'(ppc_q[l][2])) << 19)
           + (76'(ppc_q[l][3]) << 38);
        q0_d[l] = nr[73:37];
      end
    end

    // E: correct the estimate; this becomes the next pending term (zero for a lane past its last order)
    always_comb begin
      logic [47:0]     qd;
      logic [NumW-1:0] rem;
      logic [36:0]     qq;
      ce_d = cd_q;
      for (int l = 0; l < 2; l++) begin
        qd  = 48'(q0_q[l]) * 48'(DIV[l]);
        rem = nd_q[l] - qd[NumW-1:0];
        qq  = (rem >= NumW'(DIV[l])) ? q0_q[l] + 37'd1 : q0_q[l];
        ce_d.term[l] = ACT[l] ? qq[TermW-1:0] : '0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ca_q  <= ca_d;
        ppa_q <= ppa_d;
        cb_q  <= ca_q;
        nb_q  <= nb_d;
        cc_q  <= cb_q;
        nc_q  <= nb_q;
        ppc_q <= ppc_d;
        cd_q  <= cc_q;
        nd_q  <= nc_q;
        q0_q  <= q0_d;
        ce_q  <= ce_d;
      end
    end

    assign grp_ctx[g+1] = ce_q;
    assign grp_vld[g+1] = ve_q;
  end

  // ---------------- final sum and saturation ----------------
  logic                 fin_vld_q;
  logic                 fin_neg_q;
  logic [1:0][AccW-1:0] fin_q;
  logic [1:0][AccW-1:0] fin_d;
  logic [31:0]          sine_q, cosine_q;
  logic [31:0]          sine_d, cosine_d;

  // last pending term has an even index, so it is added
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      fin_d[l] = grp_ctx[NumGroups].acc[l] + {1'b0, grp_ctx[NumGroups].term[l]};
    end
  end

  always_comb begin
    logic [AccW-1:0] mag_s, mag_c;
    logic            sgn_s;
    mag_s = fin_q[LaneSin][AccW-1] ? -fin_q[LaneSin] : fin_q[LaneSin];
    mag_c = fin_q[LaneCos][AccW-1] ? -fin_q[LaneCos] : fin_q[LaneCos];
    if (mag_s > AccW'(OneW)) mag_s = AccW'(OneW);
    if (mag_c > AccW'(OneW)) mag_c = AccW'(OneW);
    sgn_s    = fin_q[LaneSin][AccW-1] ^ fin_neg_q;
    sine_d   = sgn_s ? 32'(-mag_s) : mag_s[31:0];
    cosine_d = fin_q[LaneCos][AccW-1] ? 32'(-mag_c) : mag_c[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      fin_vld_q <= grp_vld[NumGroups];
      out_vld_q <= fin_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q     <= fin_d;
      fin_neg_q <= grp_ctx[NumGroups].neg;
      sine_q    <= sine_d;
      cosine_q  <= cosine_d;
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.sine   = sine_q;
  assign out_o.cosine = cosine_q;

  // ---------------- assertions ----------------
  a_sine_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ($signed(out_o.sine) <= 32'sh4000_0000 &&
                     $signed(out_o.sine) >= -32'sh4000_0000))
    else $error("sine outside +-1.0");

  a_cosine_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ($signed(out_o.cosine) <= 32'sh4000_0000 &&
                     $signed(out_o.cosine) >= -32'sh4000_0000))
    else $error("cosine outside +-1.0");

  a_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (a_q <= PiA))
    else $error("reduced angle beyond pi");

  a_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v0_q)
    else $error("accepted transfer not captured");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v3_q) && $stable(fin_vld_q)))
    else $error("pipeline moved during stall");

endmodule
